[design/mjt_pkg.sv]
// Shared types and constants for the joint TLB.
package mjt_pkg;

  localparam int unsigned BaseShift = 12;
  localparam int unsigned PaWidth = 38;

  typedef enum logic [2:0] {
    ACT_TRANSLATE = 3'd0,
    ACT_PROBE     = 3'd1,
    ACT_WRITE_IDX = 3'd2,
    ACT_WRITE_RND = 3'd3,
    ACT_READ      = 3'd4,
    ACT_TICK      = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REFILL   = 3'd1,
    ST_INVALID  = 3'd2,
    ST_MODIFIED = 3'd3,
    ST_INDEX    = 3'd4
  } status_e;

  // Stored tag: vpn2, asid, mask, global.
  typedef struct packed {
    logic [18:0] vpn2;
    logic [7:0]  asid;
    logic [11:0] mask;
    logic        glob;
  } tag_t;

  // Stored page word: pfn, cache, dirty, valid.
  typedef struct packed {
    logic [25:0] pfn;
    logic [2:0]  cache;
    logic        dirty;
    logic        valid;
  } page_t;

  localparam int unsigned EntryWidth = $bits(tag_t) + 2 * $bits(page_t);

  // Pack an EntryLo word into the stored page form.
  function automatic page_t pack_page(input logic [31:0] lo);
    page_t p;
    p.pfn   = lo[31:6];
    p.cache = lo[5:3];
    p.dirty = lo[2];
    p.valid = lo[1];
    return p;
  endfunction

  // Rebuild an EntryLo word with the given global bit.
  function automatic logic [31:0] unpack_page(input page_t p, input logic g);
    return {p.pfn, p.cache, p.dirty, p.valid, g};
  endfunction

  // Number of trailing ones of a mask.
  function automatic logic [3:0] mask_width(input logic [11:0] m);
    logic [3:0] n;
    logic       run;
    n = '0;
    run = 1'b1;
    for (int i = 0; i < 12; i++) begin
      run = run & m[i];
      n = n + {3'd0, run};
    end
    return n;
  endfunction

endpackage

[design/mjt_ram.sv]
// Generic single-port RAM with registered read.
module mjt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/mjt_match.sv]
// Tag array held in flops, reset to zero, with an associative match sweep over all tags.
module mjt_match
  import mjt_pkg::*;
#(
  parameter int unsigned Entries = 16,
  parameter int unsigned MaxPageShift = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [$clog2(Entries)-1:0] waddr_i,
  input  logic [18:0]                wvpn2_i,
  input  logic [7:0]                 wasid_i,
  input  logic [11:0]                wmask_i,
  input  logic                       wglob_i,
  input  logic [$clog2(Entries)-1:0] raddr_i,
  output tag_t                       rtag_o,
  input  logic [18:0]                vpn2_i,
  input  logic [7:0]                 asid_i,
  output logic                       hit_o,
  output logic [$clog2(Entries)-1:0] hit_idx_o
);

  localparam int unsigned IdxW = $clog2(Entries);

  tag_t             tag_q [Entries];
  logic [Entries-1:0] hit_vec;
  logic [11:0]        legal;

  // Page masks outside the legal set are stored as zero.
  always_comb begin
    legal = '0;
    for (int i = 0; i + BaseShift <= MaxPageShift && i < 13; i += 2) begin
      if (wmask_i == 12'((13'd1 << i) - 13'd1)) begin
        legal = wmask_i;
      end
    end
  end

  // Tags live in flops: every entry is compared in parallel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        tag_q[i] <= '0;
      end
    end else if (we_i) begin
      tag_q[waddr_i] <= '{vpn2: wvpn2_i, asid: wasid_i, mask: legal, glob: wglob_i};
    end
  end

  assign rtag_o = tag_q[raddr_i];

  // Per-entry compare and lowest-index priority pick.
  always_comb begin
    hit_idx_o = '0;
    for (int i = 0; i < Entries; i++) begin
      hit_vec[i] = (((tag_q[i].vpn2 ^ vpn2_i) & ~{7'd0, tag_q[i].mask}) == '0) &&
                   ((tag_q[i].asid == asid_i) || tag_q[i].glob);
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx_o = IdxW'(i);
      end
    end
    hit_o = |hit_vec;
  end

endmodule

[design/mips_joint_tlb_core.sv]
// Top level of the joint TLB: command decode, page memories and result register.
//
// Usage: raise start with an action and its operands; the word is taken
// when start is high and busy is low. The page memories (synchronous
// RAM) are read at acceptance; in S_MEM the result register is loaded,
// presenting one result word with done_o high for exactly one cycle.
// The receiver cannot stall; the result is simply shown for that cycle.
// busy is high until that result cycle is over, so no new word is taken
// before the last one is through. The delay is set by the registered
// page memory read and then the result register. Tags sit in flops and
// are matched in parallel at acceptance. Configuration: cfg_we_i with
// cfg_idx_i and cfg_wdata_i writes wired_limit (index 0) or tlb_enable
// (index 1); the user must do so only while idle, the block does not
// enforce it. Reset clears tags, page memories valid bits, the random
// slot and sets tlb_enable. Page memories get valid bits so they read as
// zero until written; no clearing pass is needed.
module mips_joint_tlb_core
  import mjt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned MAX_PAGE_SHIFT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic [2:0]  action_i,
  input  logic [5:0]  entry_index_i,
  input  logic [31:0] virtual_address_i,
  input  logic        is_store_i,
  input  logic        kernel_mode_i,
  input  logic [7:0]  current_asid_i,
  input  logic [18:0] tag_vpn2_i,
  input  logic [11:0] size_mask_i,
  input  logic [31:0] entry_lo_even_i,
  input  logic [31:0] entry_lo_odd_i,
  output logic [2:0]  status_o,
  output logic [37:0] physical_address_o,
  output logic        match_found_o,
  output logic [3:0]  match_index_o,
  output logic [18:0] read_vpn2_o,
  output logic [7:0]  read_asid_o,
  output logic [11:0] read_size_mask_o,
  output logic [31:0] read_lo_even_o,
  output logic [31:0] read_lo_odd_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned PageW = 2 * $bits(page_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MEM,
    S_OUT
  } state_e;

  state_e          state_q;
  logic [3:0]      wired_q;
  logic            enable_q;
  logic [IdxW-1:0] rnd_q;
  logic [ENTRIES-1:0] pvalid_q;

  // Operands latched at acceptance.
  action_e         act_q;
  logic [31:0]     va_q;
  logic            store_q, bypass_q, err_q, hit_q;
  logic [IdxW-1:0] idx_q;
  tag_t            tag_q;

  logic            accept;
  action_e         act;
  logic [18:0]     look_vpn2;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic [IdxW-1:0] look_idx;
  logic [IdxW-1:0] mem_addr;
  logic            idx_ok;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  tag_t            rtag;
  logic [PageW-1:0] page_rd;
  page_t           pg_even, pg_odd, pg_sel;
  logic [3:0]      mw;
  logic [37:0]     hi_mask;
  logic [37:0]     pa;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign act    = action_e'(action_i);
  assign idx_ok = ({26'd0, entry_index_i} < 32'(ENTRIES));

  // Translate matches on va[31:13]; probe on tag_vpn2.
  assign look_vpn2 = (act == ACT_TRANSLATE) ? virtual_address_i[31:13] : tag_vpn2_i;

  // Entry whose tag is kept: the read index or the matching entry.
  assign look_idx = (act == ACT_READ) ? entry_index_i[IdxW-1:0] : hit_idx;

  // Entry written this cycle, if any.
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = rnd_q;
    if (accept && act == ACT_WRITE_IDX && idx_ok) begin
      wr_en  = 1'b1;
      wr_idx = entry_index_i[IdxW-1:0];
    end else if (accept && act == ACT_WRITE_RND) begin
      wr_en  = 1'b1;
    end
  end

  mjt_match #(
    .Entries      (ENTRIES),
    .MaxPageShift (MAX_PAGE_SHIFT)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (wr_en),
    .waddr_i   (wr_idx),
    .wvpn2_i   (tag_vpn2_i),
    .wasid_i   (current_asid_i),
    .wmask_i   (size_mask_i),
    .wglob_i   (entry_lo_even_i[0]),
    .raddr_i   (look_idx),
    .rtag_o    (rtag),
    .vpn2_i    (look_vpn2),
    .asid_i    (current_asid_i),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  // Page memory address: write target, read index or translation hit.
  always_comb begin
    if (wr_en) begin
      mem_addr = wr_idx;
    end else if (act == ACT_READ) begin
      mem_addr = entry_index_i[IdxW-1:0];
    end else begin
      mem_addr = hit_idx;
    end
  end

  mjt_ram #(
    .Width (PageW),
    .Depth (2 ** IdxW)
  ) u_pages (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (mem_addr),
    .wdata_i ({pack_page(entry_lo_even_i), pack_page(entry_lo_odd_i)}),
    .rdata_o (page_rd)
  );

  // Unwritten entries read as zero.
  assign pg_even = pvalid_q[idx_q] ? page_t'(page_rd[PageW-1:PageW/2]) : '0;
  assign pg_odd  = pvalid_q[idx_q] ? page_t'(page_rd[PageW/2-1:0]) : '0;

  // Physical address from the selected page; the page offset comes from the address.
  always_comb begin
    mw      = mask_width(tag_q.mask);
    pg_sel  = va_q[BaseShift + 32'(mw)] ? pg_odd : pg_even;
    hi_mask = (~{26'd0, tag_q.mask}) << BaseShift;
    pa      = (({pg_sel.pfn, 12'd0}) & hi_mask) | ({6'd0, va_q} & ~hi_mask);
  end

  // Control, configuration and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      wired_q            <= '0;
      enable_q           <= 1'b1;
      rnd_q              <= '0;
      pvalid_q           <= '0;
      done_o             <= 1'b0;
      act_q              <= ACT_TRANSLATE;
      va_q               <= '0;
      store_q            <= 1'b0;
      bypass_q           <= 1'b0;
      hit_q              <= 1'b0;
      err_q              <= 1'b0;
      idx_q              <= '0;
      tag_q              <= '0;
      status_o           <= ST_OK;
      physical_address_o <= '0;
      match_found_o      <= 1'b0;
      match_index_o      <= '0;
      read_vpn2_o        <= '0;
      read_asid_o        <= '0;
      read_size_mask_o   <= '0;
      read_lo_even_o     <= '0;
      read_lo_odd_o      <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'b0) begin
          wired_q <= cfg_wdata_i;
        end else begin
          enable_q <= cfg_wdata_i[0];
        end
      end
      if (wr_en) begin
        pvalid_q[wr_idx] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q  <= S_MEM;
            act_q    <= act;
            va_q     <= virtual_address_i;
            store_q  <= is_store_i;
            bypass_q <= !enable_q || kernel_mode_i;
            hit_q    <= hit;
            err_q    <= !idx_ok;
            idx_q    <= look_idx;
            tag_q    <= rtag;
            if (act == ACT_TICK) begin
              if ({{(32-IdxW){1'b0}}, rnd_q} <= {28'd0, wired_q}) begin
                rnd_q <= IdxW'(ENTRIES - 1);
              end else begin
                rnd_q <= rnd_q - 1'b1;
              end
            end
          end
        end
        S_MEM: begin
          state_q <= S_OUT;
          done_o  <= 1'b1;
          status_o           <= ST_OK;
          physical_address_o <= '0;
          match_found_o      <= 1'b0;
          match_index_o      <= '0;
          read_vpn2_o        <= '0;
          read_asid_o        <= '0;
          read_size_mask_o   <= '0;
          read_lo_even_o     <= '0;
          read_lo_odd_o      <= '0;
          unique case (act_q)
            ACT_TRANSLATE: begin
              if (bypass_q) begin
                physical_address_o <= {6'd0, va_q};
              end else if (!hit_q) begin
                status_o <= ST_REFILL;
              end else if (!pg_sel.valid) begin
                status_o <= ST_INVALID;
              end else if (!pg_sel.dirty && store_q) begin
                status_o <= ST_MODIFIED;
              end else begin
                physical_address_o <= pa;
              end
            end
            ACT_PROBE: begin
              match_found_o <= hit_q;
              match_index_o <= hit_q ? 4'(idx_q) : 4'd0;
            end
            ACT_WRITE_IDX: begin
              if (err_q) status_o <= ST_INDEX;
            end
            ACT_READ: begin
              if (err_q) begin
                status_o <= ST_INDEX;
              end else begin
                read_vpn2_o      <= tag_q.vpn2;
                read_asid_o      <= tag_q.asid;
                read_size_mask_o <= tag_q.mask;
                read_lo_even_o   <= unpack_page(pg_even, tag_q.glob);
                read_lo_odd_o    <= unpack_page(pg_odd, tag_q.glob);
              end
            end
            default: begin
            end
          endcase
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Random slot always stays below the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-IdxW){1'b0}}, rnd_q} < 32'(ENTRIES))
    else $error("random slot out of range");

  // A result word with done_o follows every accepted word, once S_MEM has passed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("missing result");

  // No word is taken while a result is still being produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result outside busy window");

endmodule

[tb/mips_joint_tlb_core_tb.sv]
// Self-checking testbench for the joint TLB core: directed table, then random commands.
module mips_joint_tlb_core_tb;
  import mjt_pkg::*;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned MaxPageShift = 24;
  localparam int unsigned RandomItems = 1080;
  localparam logic CfgWired = 1'b0;
  localparam logic CfgEnable = 1'b1;

  // One command word as driven on the input ports.
  typedef struct packed {
    action_e     action;
    logic [5:0]  index;
    logic [31:0] vaddr;
    logic        store;
    logic        kernel;
    logic [7:0]  asid;
    logic [18:0] vpn2;
    logic [11:0] mask;
    logic [31:0] lo_even;
    logic [31:0] lo_odd;
  } cmd_t;

  // One result word as seen on the output ports.
  typedef struct packed {
    logic [2:0]  status;
    logic [37:0] paddr;
    logic        found;
    logic [3:0]  match_idx;
    logic [18:0] rd_vpn2;
    logic [7:0]  rd_asid;
    logic [11:0] rd_mask;
    logic [31:0] rd_lo_even;
    logic [31:0] rd_lo_odd;
  } result_t;

  // Directed row: a command and, where obvious, its typed result.
  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        done_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [3:0]  cfg_wdata_i;
  cmd_t        cmd_q;
  result_t     dut_res;

  mips_joint_tlb_core #(
    .ENTRIES(NumEntries),
    .MAX_PAGE_SHIFT(MaxPageShift)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .done_o            (done_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .action_i          (cmd_q.action),
    .entry_index_i     (cmd_q.index),
    .virtual_address_i (cmd_q.vaddr),
    .is_store_i        (cmd_q.store),
    .kernel_mode_i     (cmd_q.kernel),
    .current_asid_i    (cmd_q.asid),
    .tag_vpn2_i        (cmd_q.vpn2),
    .size_mask_i       (cmd_q.mask),
    .entry_lo_even_i   (cmd_q.lo_even),
    .entry_lo_odd_i    (cmd_q.lo_odd),
    .status_o          (dut_res.status),
    .physical_address_o(dut_res.paddr),
    .match_found_o     (dut_res.found),
    .match_index_o     (dut_res.match_idx),
    .read_vpn2_o       (dut_res.rd_vpn2),
    .read_asid_o       (dut_res.rd_asid),
    .read_size_mask_o  (dut_res.rd_mask),
    .read_lo_even_o    (dut_res.rd_lo_even),
    .read_lo_odd_o     (dut_res.rd_lo_odd)
  );

  // Shadow copy of the TLB contents and registers.
  tag_t        shadow_tag[NumEntries];
  page_t       shadow_even[NumEntries];
  page_t       shadow_odd[NumEntries];
  logic [3:0]  shadow_slot;
  logic [3:0]  shadow_wired;
  logic        shadow_enable;

  result_t     pending_words[$];
  int unsigned mismatches;

  logic [18:0] vpn_pool[4];
  logic [7:0]  asid_pool[4];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Lowest entry matching a VPN2 and ASID, or -1.
  function automatic int lookup_entry(logic [18:0] vpn2, logic [7:0] asid);
    logic [18:0] keep;
    for (int i = 0; i < NumEntries; i++) begin
      keep = ~{7'd0, shadow_tag[i].mask};
      if ((shadow_tag[i].vpn2 & keep) == (vpn2 & keep) &&
          (shadow_tag[i].asid == asid || shadow_tag[i].glob))
        return i;
    end
    return -1;
  endfunction

  // Masks that are not a power-of-four size are stored as zero.
  function automatic logic [11:0] sanitize_mask(logic [11:0] m);
    for (int i = 0; i + 12 <= MaxPageShift; i += 2)
      if ({20'd0, m} == (32'd1 << i) - 1) return m;
    return '0;
  endfunction

  function automatic page_t to_page(logic [31:0] lo);
    page_t p;
    p = '{pfn: lo[31:6], cache: lo[5:3], dirty: lo[2], valid: lo[1]};
    return p;
  endfunction

  // Computes the result of one command and updates the shadow state.
  function automatic result_t tlb_predict(cmd_t c);
    result_t     r;
    int          hit;
    int unsigned width;
    page_t       pg;
    logic [63:0] hi;
    logic [63:0] pa;
    logic [5:0]  slot;
    r = '0;
    case (c.action)
      ACT_TRANSLATE: begin
        if (!shadow_enable || c.kernel) begin
          r.paddr = {6'd0, c.vaddr};
        end else begin
          hit = lookup_entry(c.vaddr[31:13], c.asid);
          if (hit < 0) begin
            r.status = ST_REFILL;
          end else begin
            width = 0;
            while (width < 12 && shadow_tag[hit].mask[width]) width++;
            pg = c.vaddr[12 + width] ? shadow_odd[hit] : shadow_even[hit];
            hi = ~{52'd0, shadow_tag[hit].mask} << 12;
            pa = (({38'd0, pg.pfn} << 12) & hi) | ({32'd0, c.vaddr} & ~hi);
            if (!pg.valid) r.status = ST_INVALID;
            else if (!pg.dirty && c.store) r.status = ST_MODIFIED;
            else r.paddr = pa[37:0];
          end
        end
      end
      ACT_PROBE: begin
        hit = lookup_entry(c.vpn2, c.asid);
        if (hit >= 0) begin
          r.found = 1'b1;
          r.match_idx = hit[3:0];
        end
      end
      ACT_WRITE_IDX, ACT_WRITE_RND: begin
        slot = (c.action == ACT_WRITE_RND) ? {2'd0, shadow_slot} : c.index;
        if (slot >= NumEntries) begin
          r.status = ST_INDEX;
        end else begin
          shadow_tag[slot] = '{vpn2: c.vpn2, asid: c.asid,
                               mask: sanitize_mask(c.mask), glob: c.lo_even[0]};
          shadow_even[slot] = to_page(c.lo_even);
          shadow_odd[slot] = to_page(c.lo_odd);
        end
      end
      ACT_READ: begin
        if (c.index >= NumEntries) begin
          r.status = ST_INDEX;
        end else begin
          r.rd_vpn2 = shadow_tag[c.index].vpn2;
          r.rd_asid = shadow_tag[c.index].asid;
          r.rd_mask = shadow_tag[c.index].mask;
          r.rd_lo_even = {shadow_even[c.index], shadow_tag[c.index].glob};
          r.rd_lo_odd = {shadow_odd[c.index], shadow_tag[c.index].glob};
        end
      end
      ACT_TICK: begin
        if (shadow_slot <= shadow_wired) shadow_slot = 4'(NumEntries - 1);
        else shadow_slot = shadow_slot - 4'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Check every result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", dut_res);
      end else if (dut_res !== pending_words[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %p, got %p", pending_words[0], dut_res);
        void'(pending_words.pop_front());
      end else begin
        void'(pending_words.pop_front());
      end
    end
  end

  // Drive one command, wait until it is taken, then idle a random while.
  task automatic issue(cmd_t c, bit typed, result_t typed_res);
    result_t r;
    int unsigned gap;
    start <= 1'b1;
    cmd_q <= c;
    do @(posedge clk_i); while (busy);
    r = tlb_predict(c);
    pending_words.push_back(typed ? typed_res : r);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Registers change only once every result word has come back.
  task automatic write_reg(logic idx, logic [3:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWired) shadow_wired = value;
    else shadow_enable = value[0];
  endtask

  function automatic cmd_t mk(action_e a, logic [5:0] idx, logic [31:0] va,
                              logic st, logic kn, logic [7:0] asid,
                              logic [18:0] vpn2, logic [11:0] mask,
                              logic [31:0] lo0, logic [31:0] lo1);
    cmd_t c;
    c = '{action: a, index: idx, vaddr: va, store: st, kernel: kn, asid: asid,
          vpn2: vpn2, mask: mask, lo_even: lo0, lo_odd: lo1};
    return c;
  endfunction

  // Random command, mostly hitting a small set of pages and ASIDs.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    logic [11:0] legal[7];
    legal = '{12'h000, 12'h003, 12'h00F, 12'h03F, 12'h0FF, 12'h3FF, 12'hFFF};
    c.index = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
    c.vaddr = {vpn_pool[$urandom_range(0, 3)], 13'($urandom)};
    if ($urandom_range(0, 5) == 0) c.vaddr = $urandom;
    c.store = 1'($urandom);
    c.kernel = ($urandom_range(0, 9) == 0);
    c.asid = ($urandom_range(0, 7) == 0) ? 8'($urandom) : asid_pool[$urandom_range(0, 3)];
    c.vpn2 = ($urandom_range(0, 7) == 0) ? 19'($urandom) : vpn_pool[$urandom_range(0, 3)];
    c.mask = ($urandom_range(0, 3) == 0) ? 12'($urandom) : legal[$urandom_range(0, 6)];
    c.lo_even = $urandom;
    c.lo_odd = $urandom;
    if ($urandom_range(0, 4) != 0) c.lo_even[1] = 1'b1;
    if ($urandom_range(0, 4) != 0) c.lo_odd[1] = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 35) c.action = ACT_TRANSLATE;
    else if (pick < 47) c.action = ACT_PROBE;
    else if (pick < 70) c.action = ACT_WRITE_IDX;
    else if (pick < 78) c.action = ACT_WRITE_RND;
    else if (pick < 90) c.action = ACT_READ;
    else c.action = ACT_TICK;
    return c;
  endfunction

  initial begin
    row_t        rows[$];
    row_t        row;
    result_t     none;
    result_t     typed_res;
    logic [3:0]  wired_plan[6];
    logic        enable_plan[6];
    none = '0;
    wired_plan = '{4'd15, 4'd0, 4'd7, 4'd15, 4'd3, 4'd14};
    enable_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgWired;
    cfg_wdata_i = '0;
    cmd_q = '0;
    mismatches = 0;
    for (int i = 0; i < NumEntries; i++) begin
      shadow_tag[i] = '0;
      shadow_even[i] = '0;
      shadow_odd[i] = '0;
    end
    shadow_slot = '0;
    shadow_wired = '0;
    shadow_enable = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed results are only the obvious ones.
    row = '{mk(ACT_READ, 6'd0, '0, 0, 0, '0, '0, '0, '0, '0), 1'b1, none};
    rows.push_back(row);
    typed_res = none;
    typed_res.status = ST_INDEX;
    row = '{mk(ACT_READ, 6'd63, '0, 0, 0, '0, '0, '0, '0, '0), 1'b1, typed_res};
    rows.push_back(row);
    row = '{mk(ACT_WRITE_IDX, 6'd16, '1, 1, 1, '1, '1, '1, '1, '1), 1'b1, typed_res};
    rows.push_back(row);
    typed_res = none;
    typed_res.paddr = 38'hFF_FFFF_FFFF & 38'h00_FFFF_FFFF;
    row = '{mk(ACT_TRANSLATE, '0, '1, 1, 1, '1, '0, '0, '0, '0), 1'b1, typed_res};
    rows.push_back(row);
    // Reset entries are zero tags with invalid pages.
    typed_res = none;
    typed_res.status = ST_INVALID;
    row = '{mk(ACT_TRANSLATE, '0, 32'h0000_1FFF, 0, 0, '0, '0, '0, '0, '0), 1'b1, typed_res};
    rows.push_back(row);
    typed_res = none;
    typed_res.status = ST_REFILL;
    row = '{mk(ACT_TRANSLATE, '0, 32'h4000_0000, 0, 0, 8'd5, '0, '0, '0, '0), 1'b1, typed_res};
    rows.push_back(row);
    // Entries with extreme fields, a bad mask and the global bit.
    row.typed = 1'b0;
    row.cmd = mk(ACT_WRITE_IDX, 6'd0, '0, 0, 0, 8'd5, 19'h12345, 12'hFFF, '1, '1);
    rows.push_back(row);
    row.cmd = mk(ACT_WRITE_IDX, 6'd15, '0, 0, 0, 8'hFF, 19'h7FFFF, 12'h007,
                 32'hFFFF_FFC2, 32'h0000_0040);
    rows.push_back(row);
    row.cmd = mk(ACT_WRITE_IDX, 6'd1, '0, 0, 0, 8'd9, 19'h00400, 12'h003,
                 32'h0001_2346, 32'h0003_4406);
    rows.push_back(row);
    row.cmd = mk(ACT_READ, 6'd0, '0, 0, 0, '0, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_READ, 6'd15, '0, 0, 0, '0, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_TRANSLATE, '0, 32'hFFFF_E123, 1, 0, 8'hFF, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_TRANSLATE, '0, 32'hFFFF_F123, 0, 0, 8'hFF, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_TRANSLATE, '0, 32'h8000_5ABC, 1, 0, 8'd9, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_TRANSLATE, '0, 32'h8000_1ABC, 1, 0, 8'd9, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_TRANSLATE, '0, 32'h2469_1FFF, 1, 0, 8'd77, '0, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_PROBE, '0, '0, 0, 0, 8'hFF, 19'h7FFFF, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_PROBE, '0, '0, 0, 0, 8'd33, 19'h55555, '0, '0, '0);
    rows.push_back(row);
    row.cmd = mk(ACT_WRITE_RND, '0, '0, 0, 0, 8'd3, 19'h00001, 12'h00F, 32'h6, 32'h2);
    rows.push_back(row);
    row.cmd = mk(ACT_TICK, '0, '0, 0, 0, '0, '0, '0, '0, '0);
    rows.push_back(row);
    rows.push_back(row);
    row.cmd = mk(ACT_WRITE_RND, '0, '0, 0, 0, 8'd4, 19'h00002, 12'h000, 32'h6, 32'h6);
    rows.push_back(row);
    row.cmd = mk(ACT_READ, 6'd14, '0, 0, 0, '0, '0, '0, '0, '0);
    rows.push_back(row);

    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].res);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgWired, wired_plan[ph]);
      write_reg(CfgEnable, enable_plan[ph]);
      for (int i = 0; i < 4; i++) begin
        vpn_pool[i] = 19'($urandom);
        asid_pool[i] = 8'($urandom);
      end
      for (int n = 0; n < RandomItems / 6; n++) issue(random_cmd(), 1'b0, none);
    end

    // Drain the outstanding result words.
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[mips_joint_tlb_core.f]
design/mjt_pkg.sv
design/mjt_ram.sv
design/mjt_match.sv
design/mips_joint_tlb_core.sv
tb/mips_joint_tlb_core_tb.sv
